### rtl/core/mcss_pkg.sv
// ----------------------------------------------------------------------------
// mcss_pkg
// shared types and constants of the markov chain state sampler
// ----------------------------------------------------------------------------
package mcss_pkg;

	localparam int MAX_STATES_DEF = 8;
	localparam int PROB_BITS_DEF  = 32;

	localparam int SUM_W   = 35;
	localparam int CNT_W   = 32;
	localparam int NS_W    = 4;
	localparam int STATE_W = 3;
	localparam int VAL_W   = 32;

	localparam logic [NS_W-1:0]  NS_RESET  = 4'd2;
	localparam logic [CNT_W-1:0] SPW_RESET = 32'd1;

	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_START = 2'd1,
		REQ_STEP  = 2'd2
	} req_e;

	localparam logic REG_NUM_STATES = 1'b0;
	localparam logic REG_STEPS      = 1'b1;

	typedef struct packed {
		logic [NS_W-1:0]  num_states;
		logic [CNT_W-1:0] steps_per_window;
	} cfg_t;

endpackage

### rtl/core/mcss_regs.sv
// ----------------------------------------------------------------------------
// mcss_regs
// apb configuration registers: state count and window length
// ----------------------------------------------------------------------------
module mcss_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output mcss_pkg::cfg_t    cfg
);

	logic [mcss_pkg::NS_W-1:0]  num_states_q;
	logic [mcss_pkg::CNT_W-1:0] steps_q;
	logic                       wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_states_q <= mcss_pkg::NS_RESET;
			steps_q      <= mcss_pkg::SPW_RESET;
		end else if (wr) begin
			case (paddr[2])
				mcss_pkg::REG_NUM_STATES: num_states_q <= pwdata[mcss_pkg::NS_W-1:0];
				mcss_pkg::REG_STEPS:      steps_q      <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			mcss_pkg::REG_NUM_STATES: prdata = {28'd0, num_states_q};
			mcss_pkg::REG_STEPS:      prdata = steps_q;
			default:                  prdata = 32'd0;
		endcase
	end

	assign cfg.num_states       = num_states_q;
	assign cfg.steps_per_window = steps_q;

endmodule

### rtl/core/mcss_rate_mem.sv
// ----------------------------------------------------------------------------
// mcss_rate_mem
// transition probability table, one write and one registered read port
// ----------------------------------------------------------------------------
module mcss_rate_mem #(
	parameter int AW = 6,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/core/mcss_seq.sv
// ----------------------------------------------------------------------------
// mcss_seq
// request decode and row walk: reads one table entry per cycle, accumulates,
// picks the next state and updates sum and step count
// ----------------------------------------------------------------------------
module mcss_seq #(
	parameter int MAX_STATES = mcss_pkg::MAX_STATES_DEF,
	parameter int PROB_BITS  = mcss_pkg::PROB_BITS_DEF,
	parameter int SW         = $clog2(MAX_STATES),
	parameter int AW         = 2 * SW
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mcss_pkg::cfg_t                 cfg,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     req_type,
	input  logic [mcss_pkg::STATE_W-1:0]   from_state,
	input  logic [mcss_pkg::STATE_W-1:0]   to_state,
	input  logic [mcss_pkg::VAL_W-1:0]     prob_value,
	input  logic [mcss_pkg::STATE_W-1:0]   start_state,
	input  logic [mcss_pkg::VAL_W-1:0]     rand_value,
	output logic                           mem_wr_en,
	output logic [AW-1:0]                  mem_wr_addr,
	output logic [PROB_BITS-1:0]           mem_wr_data,
	output logic                           mem_rd_en,
	output logic [AW-1:0]                  mem_rd_addr,
	input  logic [PROB_BITS-1:0]           mem_rd_data,
	output logic                           result_valid,
	output logic [mcss_pkg::STATE_W-1:0]   next_state,
	output logic [mcss_pkg::SUM_W-1:0]     state_sum,
	output logic                           window_done,
	output logic                           row_short
);

	localparam int CUMW = PROB_BITS + SW;
	localparam int NW   = $clog2(MAX_STATES + 1);
	localparam int CW   = (NW > mcss_pkg::NS_W) ? NW : mcss_pkg::NS_W;
	localparam int SUMW = mcss_pkg::SUM_W;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} st_t;

	function automatic logic [SW-1:0] fold(input logic [mcss_pkg::STATE_W-1:0] v);
		logic [7:0] t;
		t = {5'd0, v};
		for (int i = 0; i < 3; i++) begin
			if (t >= 8'(MAX_STATES)) t = t - 8'(MAX_STATES);
		end
		return t[SW-1:0];
	endfunction

	st_t                   state_q;
	logic [SW-1:0]         cur_q;
	logic [SUMW-1:0]       sum_q;
	logic [mcss_pkg::CNT_W-1:0] cnt_q;
	logic                  issuing_q;
	logic                  valid_s1;
	logic [SW-1:0]         col_s1;
	logic [SW-1:0]         iss_col_q;
	logic [SW-1:0]         last_q;
	logic [PROB_BITS-1:0]  r_q;
	logic [CUMW-1:0]       cum_q;

	logic                  accept;
	logic [CW-1:0]         ns_ext;
	logic [CW-1:0]         n_use;
	logic [SW-1:0]         last_d;
	logic [47:0]           prob_ext;
	logic [47:0]           rand_ext;
	logic [CUMW-1:0]       cum_nx;
	logic                  hit;
	logic                  fin;
	logic [SW-1:0]         pick;
	logic [SUMW:0]         sum_nx;
	logic [SUMW-1:0]       sum_sat;
	logic [mcss_pkg::CNT_W-1:0] cnt_nx;
	logic [7:0]            pick_ext;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign ns_ext = CW'(cfg.num_states);
	always_comb begin
		if (ns_ext == '0) n_use = CW'(1);
		else if (ns_ext > CW'(MAX_STATES)) n_use = CW'(MAX_STATES);
		else n_use = ns_ext;
	end
	assign last_d = SW'(n_use - CW'(1));

	assign prob_ext = {16'd0, prob_value};
	assign rand_ext = {16'd0, rand_value};

	assign mem_wr_en   = accept && (req_type == mcss_pkg::REQ_LOAD);
	assign mem_wr_addr = {fold(from_state), fold(to_state)};
	assign mem_wr_data = prob_ext[PROB_BITS-1:0];
	assign mem_rd_en   = (state_q == ST_RUN) && issuing_q;
	assign mem_rd_addr = {cur_q, iss_col_q};

	assign cum_nx  = cum_q + CUMW'(mem_rd_data);
	assign hit     = CUMW'(r_q) <= cum_nx;
	assign fin     = valid_s1 && (hit || (col_s1 == last_q));
	assign pick    = hit ? col_s1 : last_q;
	assign sum_nx  = {1'b0, sum_q} + (SUMW+1)'(pick);
	assign sum_sat = sum_nx[SUMW] ? {SUMW{1'b1}} : sum_nx[SUMW-1:0];
	assign cnt_nx  = cnt_q + 32'd1;
	assign pick_ext = 8'(pick);

	// control and chain state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cur_q        <= '0;
			sum_q        <= '0;
			cnt_q        <= '0;
			issuing_q    <= 1'b0;
			valid_s1     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req_type)
							mcss_pkg::REQ_START: begin
								cur_q <= fold(start_state);
								sum_q <= '0;
								cnt_q <= '0;
							end
							mcss_pkg::REQ_STEP: begin
								state_q   <= ST_RUN;
								issuing_q <= 1'b1;
							end
							default: ;
						endcase
					end
				end
				ST_RUN: begin
					valid_s1 <= issuing_q && !fin;
					if (issuing_q && (iss_col_q == last_q)) issuing_q <= 1'b0;
					if (fin) begin
						state_q      <= ST_IDLE;
						issuing_q    <= 1'b0;
						cur_q        <= pick;
						sum_q        <= sum_sat;
						cnt_q        <= cnt_nx;
						result_valid <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// walk payload and result beat
	always_ff @(posedge clk) begin
		if (accept && (req_type == mcss_pkg::REQ_STEP)) begin
			iss_col_q <= '0;
			cum_q     <= '0;
			r_q       <= rand_ext[PROB_BITS-1:0];
			last_q    <= last_d;
		end else if (state_q == ST_RUN) begin
			if (issuing_q) iss_col_q <= iss_col_q + SW'(1);
			col_s1 <= iss_col_q;
			if (valid_s1) cum_q <= cum_nx;
		end
		if (fin && (state_q == ST_RUN)) begin
			next_state  <= pick_ext[mcss_pkg::STATE_W-1:0];
			state_sum   <= sum_sat;
			window_done <= (cnt_nx == cfg.steps_per_window);
			row_short   <= !hit;
		end
	end

	a_beat_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q == ST_RUN))
		else $error("result beat without a finished walk");

	a_valid_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (state_q == ST_RUN))
		else $error("read data pending outside a walk");

	a_issue_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		mem_rd_en |-> (iss_col_q <= last_q))
		else $error("read issued past the last state in use");

	a_cur_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, cur_q} < (SW+1)'(MAX_STATES)))
		else $error("current state outside the table");

	a_no_write_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> !mem_wr_en)
		else $error("table write during a walk");

endmodule

### rtl/core/markov_chain_state_sampler.sv
// ----------------------------------------------------------------------------
// markov_chain_state_sampler
// discrete-time markov chain with inverse-cdf sampling over a stored table
// ----------------------------------------------------------------------------
// A load or start item leaves busy low and the next item may follow at once.
// A step item walks the current row of the table memory, one entry read and
// accumulated per cycle through its registered read port, and holds busy
// until the next state is picked; its result beat shows on the cycle busy
// falls. The result beat is a single-cycle strobe on result_valid and is not
// held: the receiver must take it in that cycle. The table has no reset and
// entries must be loaded before a step reads them.
module markov_chain_state_sampler #(
	parameter int MAX_STATES = mcss_pkg::MAX_STATES_DEF,
	parameter int PROB_BITS  = mcss_pkg::PROB_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [2:0]                     paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     req_type,
	input  logic [mcss_pkg::STATE_W-1:0]   from_state,
	input  logic [mcss_pkg::STATE_W-1:0]   to_state,
	input  logic [mcss_pkg::VAL_W-1:0]     prob_value,
	input  logic [mcss_pkg::STATE_W-1:0]   start_state,
	input  logic [mcss_pkg::VAL_W-1:0]     rand_value,
	output logic                           result_valid,
	output logic [mcss_pkg::STATE_W-1:0]   next_state,
	output logic [mcss_pkg::SUM_W-1:0]     state_sum,
	output logic                           window_done,
	output logic                           row_short
);

	localparam int SW = $clog2(MAX_STATES);
	localparam int AW = 2 * SW;

	mcss_pkg::cfg_t         cfg;
	logic                   mem_wr_en;
	logic [AW-1:0]          mem_wr_addr;
	logic [PROB_BITS-1:0]   mem_wr_data;
	logic                   mem_rd_en;
	logic [AW-1:0]          mem_rd_addr;
	logic [PROB_BITS-1:0]   mem_rd_data;

	mcss_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mcss_rate_mem #(
		.AW (AW),
		.DW (PROB_BITS)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	mcss_seq #(
		.MAX_STATES (MAX_STATES),
		.PROB_BITS  (PROB_BITS),
		.SW         (SW),
		.AW         (AW)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.from_state   (from_state),
		.to_state     (to_state),
		.prob_value   (prob_value),
		.start_state  (start_state),
		.rand_value   (rand_value),
		.mem_wr_en    (mem_wr_en),
		.mem_wr_addr  (mem_wr_addr),
		.mem_wr_data  (mem_wr_data),
		.mem_rd_en    (mem_rd_en),
		.mem_rd_addr  (mem_rd_addr),
		.mem_rd_data  (mem_rd_data),
		.result_valid (result_valid),
		.next_state   (next_state),
		.state_sum    (state_sum),
		.window_done  (window_done),
		.row_short    (row_short)
	);

endmodule
